/* rtl/ppq_pkg.sv */
// ppq_pkg: shared types, constants and helpers for the playback queue
// used by ppq_ctrl, ppq_datapath and preemptive_playback_queue_core
`timescale 1ns / 1ps

package ppq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// field widths
	localparam int ID_W   = 8;
	localparam int GAIN_W = 9;
	localparam int DROP_W = 5;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(256);
	localparam logic [GAIN_W-1:0] DUCK_RESET = GAIN_W'(128);
	localparam logic [DROP_W-1:0] DROP_MAX   = '1;

	// input item kinds
	localparam logic KIND_PLAY    = 1'b0;
	localparam logic KIND_RETRACT = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] track_id;
		logic            interrupting;
	} in_item_t;

	typedef struct packed {
		logic              play_valid;
		logic [ID_W-1:0]   play_id;
		logic              stop_valid;
		logic [ID_W-1:0]   stop_id;
		logic              duck_active;
		logic [GAIN_W-1:0] background_gain;
		logic [DROP_W-1:0] dropped_count;
		logic              overflow;
	} result_t;

	// what an incoming item turns into, given the current state
	typedef enum logic [2:0] {
		CL_PLAY,
		CL_ENQUEUE,
		CL_OVERFLOW,
		CL_RELEASE,
		CL_POP,
		CL_SCAN
	} item_class_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PLAY,
		OP_ENQUEUE,
		OP_OVERFLOW,
		OP_RELEASE,
		OP_POP_RD,
		OP_POP_WR,
		OP_SCAN_START,
		OP_SCAN_STEP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN
	} state_t;

	typedef struct packed {
		op_t  op;
		logic finish;
	} cmd_t;

	typedef struct packed {
		item_class_t cls;
		logic        count_zero;
		logic        scan_last;
	} status_t;

	// circular index add, base below the depth, offset at most the depth
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
	                                              input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	// gain clamp to unity
	function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
		return (g > UNITY_GAIN) ? UNITY_GAIN : g;
	endfunction

	// discard count clamp to the field width
	function automatic logic [DROP_W-1:0] sat_drop(input logic [CNT_W-1:0] c);
		logic [CNT_W+DROP_W-1:0] ext;
		ext = (CNT_W + DROP_W)'(c);
		if (ext > (CNT_W + DROP_W)'(DROP_MAX))
			return DROP_MAX;
		return ext[DROP_W-1:0];
	endfunction

endpackage

/* rtl/preemptive_playback_queue_core.sv */
// preemptive_playback_queue_core: top level, depends on ppq_pkg, ppq_ctrl and ppq_datapath
// play, enqueue, overflow, release and a retract with an empty queue finish straight from idle;
// a retract of the playing clip with clips waiting reads the queue head, then starts it;
// a retract of a queued id walks the wait queue; one item at a time, taken while not busy
// results are strobed on done for one cycle; the receiver cannot stall
// reset (arst_n low, async): nothing playing, queue empty, duck gain 128, queue memory not cleared
`timescale 1ns / 1ps

module preemptive_playback_queue_core
	import ppq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	output result_t           result,
	output logic              done,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [GAIN_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// config beat taken only while idle with no item offered
	assign cfg_ready = !busy && !start;

	ppq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	ppq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

endmodule

/* rtl/ppq_ctrl.sv */
// ppq_ctrl: sequencer for the playback queue, one item at a time
// depends on ppq_pkg; drives ppq_datapath through cmd_t / status_t
`timescale 1ns / 1ps

module ppq_ctrl
	import ppq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		busy       = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (status.cls)
						CL_PLAY: begin
							cmd.op     = OP_PLAY;
							cmd.finish = 1'b1;
						end
						CL_ENQUEUE: begin
							cmd.op     = OP_ENQUEUE;
							cmd.finish = 1'b1;
						end
						CL_OVERFLOW: begin
							cmd.op     = OP_OVERFLOW;
							cmd.finish = 1'b1;
						end
						CL_RELEASE: begin
							cmd.op     = OP_RELEASE;
							cmd.finish = 1'b1;
						end
						CL_POP: begin
							cmd.op  = OP_POP_RD;
							state_d = ST_POP;
						end
						CL_SCAN: begin
							cmd.op = OP_SCAN_START;
							if (status.count_zero)
								cmd.finish = 1'b1;
							else
								state_d = ST_SCAN;
						end
						default: begin
							cmd.op = OP_NONE;
						end
					endcase
				end
			end
			ST_POP: begin
				cmd.op     = OP_POP_WR;
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (status.scan_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/ppq_datapath.sv */
// ppq_datapath: wait queue memory, playback state, gain register, result register
// depends on ppq_pkg; sequenced by ppq_ctrl
`timescale 1ns / 1ps

module ppq_datapath
	import ppq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  in_item_t          item,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              cfg_we,
	input  logic [GAIN_W-1:0] cfg_data,
	output result_t           result,
	output logic              done
);

	// wait queue storage, circular
	logic [ID_W-1:0]  mem [QUEUE_DEPTH];
	logic [ID_W-1:0]  rd_data_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [ID_W-1:0]  mem_wd;
	logic             mem_re;
	logic [IDX_W-1:0] mem_ra;

	// playback state
	logic [IDX_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ID_W-1:0]   cur_id_q, cur_id_d;
	logic              cur_valid_q, cur_valid_d;
	logic              ducked_q, ducked_d;
	logic [GAIN_W-1:0] duck_gain_q;

	// scan walk
	logic [ID_W-1:0]  id_q, id_d;
	logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;

	// result
	result_t res_q, res_d;
	logic    done_q;

	// classify the incoming item
	always_comb begin
		if (item.kind == KIND_PLAY) begin
			if (item.interrupting || (count_q == '0 && !cur_valid_q))
				status.cls = CL_PLAY;
			else if (count_q >= CNT_W'(QUEUE_DEPTH))
				status.cls = CL_OVERFLOW;
			else
				status.cls = CL_ENQUEUE;
		end else begin
			if (cur_valid_q && item.track_id == cur_id_q)
				status.cls = (count_q != '0) ? CL_POP : CL_RELEASE;
			else
				status.cls = CL_SCAN;
		end
		status.count_zero = (count_q == '0);
		status.scan_last  = (rd_ptr_q == count_q);
	end

	// next state per operation
	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		cur_id_d    = cur_id_q;
		cur_valid_d = cur_valid_q;
		ducked_d    = ducked_q;
		id_d        = id_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		mem_we      = 1'b0;
		mem_wa      = wrap_add(head_q, count_q);
		mem_wd      = item.track_id;
		mem_re      = 1'b0;
		mem_ra      = head_q;
		res_d       = '0;
		case (cmd.op)
			OP_PLAY: begin
				if (cur_valid_q) begin
					res_d.stop_valid = 1'b1;
					res_d.stop_id    = cur_id_q;
				end
				res_d.dropped_count = sat_drop(count_q);
				res_d.play_valid    = 1'b1;
				res_d.play_id       = item.track_id;
				count_d             = '0;
				cur_id_d            = item.track_id;
				cur_valid_d         = 1'b1;
				ducked_d            = 1'b1;
			end
			OP_ENQUEUE: begin
				mem_we  = 1'b1;
				count_d = count_q + CNT_W'(1);
			end
			OP_OVERFLOW: begin
				res_d.overflow = 1'b1;
			end
			OP_RELEASE: begin
				cur_valid_d = 1'b0;
				cur_id_d    = '0;
				ducked_d    = 1'b0;
			end
			OP_POP_RD: begin
				mem_re = 1'b1;
			end
			OP_POP_WR: begin
				cur_id_d         = rd_data_q;
				res_d.play_valid = 1'b1;
				res_d.play_id    = rd_data_q;
				head_d           = wrap_add(head_q, CNT_W'(1));
				count_d          = count_q - CNT_W'(1);
			end
			OP_SCAN_START: begin
				id_d     = item.track_id;
				mem_re   = 1'b1;
				rd_ptr_d = CNT_W'(1);
				wr_ptr_d = '0;
			end
			OP_SCAN_STEP: begin
				// keep the entry read last cycle unless it matches
				if (rd_data_q != id_q) begin
					mem_we   = 1'b1;
					mem_wa   = wrap_add(head_q, wr_ptr_q);
					mem_wd   = rd_data_q;
					wr_ptr_d = wr_ptr_q + CNT_W'(1);
				end
				if (rd_ptr_q != count_q) begin
					mem_re   = 1'b1;
					mem_ra   = wrap_add(head_q, rd_ptr_q);
					rd_ptr_d = rd_ptr_q + CNT_W'(1);
				end else begin
					count_d = wr_ptr_d;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		res_d.duck_active     = ducked_d;
		res_d.background_gain = ducked_d ? sat_gain(duck_gain_q) : UNITY_GAIN;
	end

	// queue memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_q <= mem[mem_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cur_id_q    <= '0;
			cur_valid_q <= 1'b0;
			ducked_q    <= 1'b0;
			duck_gain_q <= DUCK_RESET;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			head_q      <= head_d;
			count_q     <= count_d;
			cur_id_q    <= cur_id_d;
			cur_valid_q <= cur_valid_d;
			ducked_q    <= ducked_d;
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			done_q      <= cmd.finish;
			if (cfg_we)
				duck_gain_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		id_q <= id_d;
		if (cmd.finish)
			res_q <= res_d;
	end

	assign result = res_q;
	assign done   = done_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_duck_tracks_play: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.duck_active == cur_valid_q))
		else $error("ducking flag disagrees with playback state");

	a_play_is_current: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.play_valid) |-> (cur_valid_q && res_q.play_id == cur_id_q))
		else $error("started clip is not the current clip");

	a_scan_compacts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN_STEP) |=> (count_q <= $past(count_q)))
		else $error("retract scan grew the queue");
`endif

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for preemptive_playback_queue_core
// depends on ppq_pkg for the item and result types and queue geometry
`timescale 1ns / 1ps

module testbench;
	import ppq_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          item;
	result_t           result;
	logic              done;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [GAIN_W-1:0] cfg_data;

	preemptive_playback_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.result    (result),
		.done      (done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// scheduler state as the bench sees it
	logic [ID_W-1:0]   waiting[$];
	logic [ID_W-1:0]   now_id;
	bit                playing;
	bit                ducking;
	logic [GAIN_W-1:0] duck_level;

	result_t expected_results[$];
	result_t want;
	int      error_count;
	int      result_count;
	bit      sender_gaps;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] exp_val);
		error_count++;
		if (error_count <= 40)
			$display("[%0t] result %0d: %s got %0h expected %0h",
			         $realtime, result_count, what, got, exp_val);
	endtask

	task automatic check_field(string name, logic [8:0] got, logic [8:0] exp_val);
		if (got !== exp_val)
			report_mismatch(name, got, exp_val);
	endtask

	// next scheduler decision and the result it produces
	function automatic result_t predict_outcome(in_item_t it);
		result_t          r;
		logic [ID_W-1:0]  kept[$];
		r = '0;
		if (it.kind == KIND_PLAY) begin
			if (it.interrupting || (waiting.size() == 0 && !playing)) begin
				if (playing) begin
					r.stop_valid = 1'b1;
					r.stop_id    = now_id;
				end
				r.dropped_count = (waiting.size() > int'(DROP_MAX)) ?
				                  DROP_MAX : DROP_W'(waiting.size());
				waiting.delete();
				r.play_valid = 1'b1;
				r.play_id    = it.track_id;
				now_id       = it.track_id;
				playing      = 1'b1;
				ducking      = 1'b1;
			end else if (waiting.size() >= QUEUE_DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				waiting.push_back(it.track_id);
			end
		end else if (playing && it.track_id == now_id) begin
			// retract of the playing clip: head takes over or go idle
			if (waiting.size() > 0) begin
				now_id       = waiting.pop_front();
				r.play_valid = 1'b1;
				r.play_id    = now_id;
			end else begin
				playing = 1'b0;
				now_id  = '0;
				ducking = 1'b0;
			end
		end else begin
			// retract of a queued id removes every match
			foreach (waiting[i])
				if (waiting[i] != it.track_id)
					kept.push_back(waiting[i]);
			waiting = kept;
		end
		r.duck_active     = ducking;
		r.background_gain = !ducking ? UNITY_GAIN :
		                    (duck_level > UNITY_GAIN) ? UNITY_GAIN : duck_level;
		return r;
	endfunction

	// result checker, the receiver never stalls
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 9'(result.play_id), 9'h0);
			end else begin
				want = expected_results.pop_front();
				check_field("play_valid", 9'(result.play_valid), 9'(want.play_valid));
				check_field("play_id", 9'(result.play_id), 9'(want.play_id));
				check_field("stop_valid", 9'(result.stop_valid), 9'(want.stop_valid));
				check_field("stop_id", 9'(result.stop_id), 9'(want.stop_id));
				check_field("duck_active", 9'(result.duck_active), 9'(want.duck_active));
				check_field("background_gain", result.background_gain,
				            want.background_gain);
				check_field("dropped_count", 9'(result.dropped_count),
				            9'(want.dropped_count));
				check_field("overflow", 9'(result.overflow), 9'(want.overflow));
			end
		end
	end

	function automatic in_item_t make_item(logic kind, logic [ID_W-1:0] id, logic intr);
		in_item_t it;
		it.kind         = kind;
		it.track_id     = id;
		it.interrupting = intr;
		return it;
	endfunction

	// one beat on the command side, with a random lead-in gap when sender gaps are on
	task automatic send_item(in_item_t it);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_outcome(it));
	endtask

	// hold off until every result is in and the walk has surely ended
	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_duck_gain(logic [GAIN_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		duck_level = value;
	endtask

	// start at once, fill to the brim, overflow, then flush by preemption
	task automatic test_fill_and_flush();
		send_item(make_item(KIND_PLAY, 8'h00, 1'b0));
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(make_item(KIND_PLAY,
			                    (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : ID_W'(i * 37),
			                    1'b0));
		send_item(make_item(KIND_PLAY, 8'h77, 1'b0));
		send_item(make_item(KIND_PLAY, 8'hFF, 1'b1));
	endtask

	// retract of playing, queued and unknown ids
	task automatic test_retract_paths();
		send_item(make_item(KIND_RETRACT, 8'hFF, 1'b1));
		send_item(make_item(KIND_RETRACT, 8'h12, 1'b0));
		send_item(make_item(KIND_PLAY, 8'h80, 1'b1));
		send_item(make_item(KIND_PLAY, 8'h33, 1'b0));
		send_item(make_item(KIND_PLAY, 8'h44, 1'b0));
		send_item(make_item(KIND_PLAY, 8'h33, 1'b0));
		send_item(make_item(KIND_PLAY, 8'h44, 1'b0));
		send_item(make_item(KIND_RETRACT, 8'h33, 1'b0));
		send_item(make_item(KIND_RETRACT, 8'h80, 1'b0));
		send_item(make_item(KIND_RETRACT, 8'h44, 1'b0));
		send_item(make_item(KIND_RETRACT, 8'h44, 1'b0));
	endtask

	// mostly meaningful items: retracts aim at live ids, requests reuse a few ids
	function automatic in_item_t random_item(int retract_pct, int intr_pct);
		logic            kind;
		logic [ID_W-1:0] id;
		int              pick;
		kind = ($urandom_range(0, 99) < retract_pct) ? KIND_RETRACT : KIND_PLAY;
		pick = $urandom_range(0, 99);
		if (kind == KIND_RETRACT && playing && pick < 40)
			id = now_id;
		else if (kind == KIND_RETRACT && waiting.size() > 0 && pick < 75)
			id = waiting[$urandom_range(0, waiting.size() - 1)];
		else if (pick < 85)
			id = ID_W'($urandom_range(0, 7));
		else
			id = ID_W'($urandom_range(0, 255));
		return make_item(kind, id, $urandom_range(0, 99) < intr_pct);
	endfunction

	task automatic run_traffic(int count, int retract_pct, int intr_pct, bit bursty);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				sender_gaps = bursty ? 1'b0 : ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 99) == 0)
				drain_results();
			send_item(random_item(retract_pct, intr_pct));
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		item        <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		duck_level  = DUCK_RESET;
		playing     = 1'b0;
		ducking     = 1'b0;
		now_id      = '0;
		sender_gaps = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_flush();
		test_retract_paths();

		write_duck_gain(9'd0);
		run_traffic(230, 30, 8, 1'b0);
		write_duck_gain(9'd256);
		run_traffic(230, 15, 3, 1'b1);
		write_duck_gain(9'h1FF);
		run_traffic(230, 50, 10, 1'b0);
		write_duck_gain(GAIN_W'($urandom_range(0, 511)));
		run_traffic(230, 25, 20, 1'b0);
		write_duck_gain(9'd255);
		run_traffic(230, 35, 6, 1'b0);

		drain_results();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
